// File: rtl/cmf_pkg.sv
package cmf_pkg;

   // Function codes of an input beat
   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_MATCH = 2'd0;
   localparam logic [1:0] KIND_FAULT = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ACK   = 2'd3;

   // Upper bound on entries examined per frame (fits the 4-bit slot field)
   localparam int WALK_CAP = 16;

   typedef struct packed {
      logic        func;
      logic [10:0] frame_id;
      logic [3:0]  frame_length;
      logic [3:0]  entry_slot;
      logic [10:0] entry_ident;
      logic [10:0] entry_mask;
      logic [3:0]  entry_length;
      logic        entry_handled;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] matched_slot;
      logic       last;
   } rsp_type;

   // One filter table entry
   typedef struct packed {
      logic        handled;
      logic [3:0]  length;
      logic [10:0] mask;
      logic [10:0] ident;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage

// File: rtl/cmf_table.sv
module cmf_table #(
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  cmf_pkg::entry_type      wr_data,
   input  logic [AW-1:0]           rd_addr,
   output cmf_pkg::entry_type      rd_data
);

   cmf_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   cmf_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;

   // Storage array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Written flags; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/can_id_mask_filter_dispatch.sv
// CAN identifier/mask acceptance filter. A write beat loads one table entry
// and returns a single acknowledge in the cycle after acceptance. A frame beat
// walks entries 0 .. min(entries_in_use, TABLE_DEPTH, 16)-1, one entry per
// cycle while the result side does not stall, through the single read port of
// the filter table, whose read address runs one entry ahead of the entry being
// judged. It emits a match result for each handled hit, and ends with a length
// fault or a done result, so a frame holds the block from acceptance through
// the walked entries to the terminal result, plus any result side stalls. One
// item is worked on at a time; a new beat is taken once the terminal result is
// in the output register and that register can accept. Table entries read as
// zero until written; no clearing pass is needed after reset.
module can_id_mask_filter_dispatch #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cmf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cmf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);

   localparam int         AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int         LIMIT   = (TABLE_DEPTH < cmf_pkg::WALK_CAP) ?
                                    TABLE_DEPTH : cmf_pkg::WALK_CAP;
   localparam logic [4:0] LIMIT_W = 5'(LIMIT);

   cmf_pkg::state_type state_ff, state_in;
   logic [4:0]         entries_ff;
   logic [4:0]         idx_ff, idx_in;
   logic [4:0]         n_ff, n_in;
   logic [10:0]        fid_ff, fid_in;
   logic [3:0]         flen_ff, flen_in;
   logic               rsp_valid_ff;
   cmf_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_load;

   logic               out_free;
   logic               req_acc;
   logic               tbl_wr_en;
   logic [AW-1:0]      tbl_wr_addr;
   cmf_pkg::entry_type tbl_wr_data;
   logic [AW-1:0]      tbl_rd_addr;
   cmf_pkg::entry_type entry;
   logic               hit;
   logic               len_ok;

   // Handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == cmf_pkg::ST_IDLE) && out_free);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Table write from a write beat; slots past the depth are dropped
   assign tbl_wr_en   = req_acc && (req_data.func == cmf_pkg::FUNC_WRITE) &&
                        (32'(req_data.entry_slot) < TABLE_DEPTH);
   assign tbl_wr_addr = AW'(req_data.entry_slot);
   assign tbl_wr_data = '{handled: req_data.entry_handled,
                          length:  req_data.entry_length,
                          mask:    req_data.entry_mask,
                          ident:   req_data.entry_ident};

   // Read one ahead: data next cycle belongs to idx_ff
   assign tbl_rd_addr = (idx_in < LIMIT_W) ? AW'(idx_in) : '0;

   cmf_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (entry)
   );

   // Entry judgement
   assign hit    = ((fid_ff & entry.mask) == entry.ident);
   assign len_ok = (entry.length == 4'd0) || (entry.length == flen_ff);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      fid_in      = fid_ff;
      flen_in     = flen_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         cmf_pkg::ST_IDLE: begin
            idx_in = 5'd0;
            if (req_acc) begin
               if (req_data.func == cmf_pkg::FUNC_WRITE) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{kind: cmf_pkg::KIND_ACK,
                                  matched_slot: req_data.entry_slot, last: 1'b1};
               end else begin
                  fid_in   = req_data.frame_id;
                  flen_in  = req_data.frame_length;
                  n_in     = (entries_ff > LIMIT_W) ? LIMIT_W : entries_ff;
                  state_in = cmf_pkg::ST_WALK;
               end
            end
         end
         cmf_pkg::ST_WALK: begin
            if (out_free) begin
               if (idx_ff == n_ff) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{kind: cmf_pkg::KIND_DONE,
                                  matched_slot: 4'd0, last: 1'b1};
                  state_in    = cmf_pkg::ST_IDLE;
                  idx_in      = 5'd0;
               end else if (hit && !len_ok) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{kind: cmf_pkg::KIND_FAULT,
                                  matched_slot: idx_ff[3:0], last: 1'b1};
                  state_in    = cmf_pkg::ST_IDLE;
                  idx_in      = 5'd0;
               end else begin
                  if (hit && entry.handled) begin
                     rsp_load    = 1'b1;
                     rsp_data_in = '{kind: cmf_pkg::KIND_MATCH,
                                     matched_slot: idx_ff[3:0], last: 1'b0};
                  end
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = cmf_pkg::ST_IDLE;
            idx_in   = 5'd0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmf_pkg::ST_IDLE;
         idx_ff       <= 5'd0;
         entries_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      fid_ff  <= fid_in;
      flen_ff <= flen_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_frame_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_data.func == cmf_pkg::FUNC_FRAME) |=> state_ff == cmf_pkg::ST_WALK)
      else $error("frame beat did not start a walk");

   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmf_pkg::ST_WALK) |-> (idx_ff <= n_ff) && (n_ff <= LIMIT_W))
      else $error("walk index beyond entry count");

   a_nonlast_is_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last |-> rsp_data_ff.kind == cmf_pkg::KIND_MATCH)
      else $error("non-final result is not a match");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten while held");

endmodule

// File: bench/tb_can_id_mask_filter_dispatch.sv
`timescale 1ns / 1ps

module tb_can_id_mask_filter_dispatch;

   localparam int DEPTH        = 16;
   localparam int RANDOM_BEATS = 450;
   localparam int PHASE_BEATS  = 64;
   localparam int QUIET_BEATS  = 60;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int NUM_VECTORS  = 20;

   // one directed row: optional walk length write, the beat, optional typed result
   typedef struct {
      logic             set_walk;
      logic [4:0]       walk;
      cmf_pkg::req_type beat;
      logic             typed;
      cmf_pkg::rsp_type result;
   } vector_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cmf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cmf_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [4:0]       csr_data  = '0;

   // predictor state
   cmf_pkg::entry_type shadow_table [DEPTH];
   logic [4:0]         walk_len;
   cmf_pkg::rsp_type   beat_results [$];
   cmf_pkg::rsp_type   pending_results [$];

   vector_type directed [NUM_VECTORS];

   int errors       = 0;
   int cycle_count  = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_burst    = 0;
   int n_writes     = 0;
   int n_frames     = 0;
   int n_match      = 0;
   int n_fault      = 0;
   int n_done       = 0;
   int n_ack        = 0;

   can_id_mask_filter_dispatch #(
      .TABLE_DEPTH (DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // result side back-pressure, in random bursts
   always @(posedge clock) begin
      if (reset || rsp_idle_pct == 0) begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
      end else if (rsp_burst != 0) begin
         rsp_burst <= rsp_burst - 1;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      cmf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         case (rsp_data.kind)
            cmf_pkg::KIND_MATCH: n_match++;
            cmf_pkg::KIND_FAULT: n_fault++;
            cmf_pkg::KIND_DONE:  n_done++;
            default:             n_ack++;
         endcase
         if (pending_results.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual kind %0d slot %0d last %0d"},
                     $time, rsp_data.kind, rsp_data.matched_slot, rsp_data.last);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.matched_slot !== want.matched_slot ||
                rsp_data.last !== want.last) begin
               $display({"%0t: mismatch: expected kind %0d slot %0d last %0d, ",
                         "actual kind %0d slot %0d last %0d"},
                        $time, want.kind, want.matched_slot, want.last,
                        rsp_data.kind, rsp_data.matched_slot, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // work out the results of one beat and update the shadow table
   function automatic void filter_beat(input cmf_pkg::req_type b);
      int                 n;
      cmf_pkg::entry_type e;
      bit                 stop;
      beat_results.delete();
      if (b.func == cmf_pkg::FUNC_WRITE) begin
         if (b.entry_slot < DEPTH)
            shadow_table[b.entry_slot] = '{b.entry_handled, b.entry_length,
                                           b.entry_mask, b.entry_ident};
         beat_results.push_back(
            cmf_pkg::rsp_type'({cmf_pkg::KIND_ACK, b.entry_slot, 1'b1}));
      end else begin
         n = walk_len;
         if (n > DEPTH) n = DEPTH;
         if (n > cmf_pkg::WALK_CAP) n = cmf_pkg::WALK_CAP;
         stop = 1'b0;
         for (int i = 0; i < n && !stop; i++) begin
            e = shadow_table[i];
            if ((b.frame_id & e.mask) == e.ident) begin
               if (e.length == 4'd0 || b.frame_length == e.length) begin
                  if (e.handled)
                     beat_results.push_back(
                        cmf_pkg::rsp_type'({cmf_pkg::KIND_MATCH, 4'(i), 1'b0}));
               end else begin
                  // length fault ends the walk
                  beat_results.push_back(
                     cmf_pkg::rsp_type'({cmf_pkg::KIND_FAULT, 4'(i), 1'b1}));
                  stop = 1'b1;
               end
            end
         end
         if (!stop)
            beat_results.push_back(
               cmf_pkg::rsp_type'({cmf_pkg::KIND_DONE, 4'd0, 1'b1}));
      end
   endfunction

   function automatic cmf_pkg::req_type frame_beat(input logic [10:0] id,
                                                   input logic [3:0] len);
      cmf_pkg::req_type b;
      b              = '0;
      b.func         = cmf_pkg::FUNC_FRAME;
      b.frame_id     = id;
      b.frame_length = len;
      return b;
   endfunction

   function automatic cmf_pkg::req_type write_beat(input logic [3:0] slot,
                                                   input logic [10:0] ident,
                                                   input logic [10:0] mask,
                                                   input logic [3:0] len,
                                                   input logic handled);
      cmf_pkg::req_type b;
      b               = '0;
      b.func          = cmf_pkg::FUNC_WRITE;
      b.entry_slot    = slot;
      b.entry_ident   = ident;
      b.entry_mask    = mask;
      b.entry_length  = len;
      b.entry_handled = handled;
      return b;
   endfunction

   // drive one beat, hold it until taken, then log what it should produce
   task automatic send_beat(input cmf_pkg::req_type b, input logic typed,
                            input cmf_pkg::rsp_type result);
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_beat(b);
      if (typed)
         pending_results.push_back(result);
      else
         foreach (beat_results[k]) pending_results.push_back(beat_results[k]);
      if (b.func == cmf_pkg::FUNC_WRITE) n_writes++;
      else n_frames++;
   endtask

   // random sender gap after a beat
   task automatic sender_gap();
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // hold off the sender until all results are in and the walk has wound down
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_walk_len(input logic [4:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      walk_len = v;
   endtask

   initial begin
      cmf_pkg::req_type   beat;
      logic [63:0]        raw;
      cmf_pkg::entry_type e;
      int                 n;
      int                 s;

      foreach (shadow_table[k]) shadow_table[k] = '0;
      walk_len = '0;

      // directed rows: reset table, extremes, handled/unhandled, faults, clamping
      directed[0]  = '{1'b0, 5'd0,  frame_beat(11'h000, 4'd0),  1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_DONE, 4'd0, 1'b1}};
      directed[1]  = '{1'b0, 5'd0,  frame_beat(11'h7FF, 4'd15), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_DONE, 4'd0, 1'b1}};
      directed[2]  = '{1'b0, 5'd0,  write_beat(4'd0, 11'h123, 11'h7FF, 4'd0, 1'b1), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd0, 1'b1}};
      directed[3]  = '{1'b0, 5'd0,  write_beat(4'd1, 11'h100, 11'h700, 4'd4, 1'b0), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd1, 1'b1}};
      directed[4]  = '{1'b0, 5'd0,  write_beat(4'd2, 11'h000, 11'h000, 4'd0, 1'b1), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd2, 1'b1}};
      directed[5]  = '{1'b0, 5'd0,  write_beat(4'd3, 11'h0F0, 11'h0FF, 4'd15, 1'b1), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd3, 1'b1}};
      directed[6]  = '{1'b0, 5'd0,  write_beat(4'd15, 11'h7FF, 11'h7FF, 4'd8, 1'b1), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd15, 1'b1}};
      directed[7]  = '{1'b1, 5'd16, frame_beat(11'h123, 4'd3),  1'b0, '0};
      directed[8]  = '{1'b0, 5'd0,  frame_beat(11'h7FF, 4'd8),  1'b0, '0};
      directed[9]  = '{1'b0, 5'd0,  frame_beat(11'h0F0, 4'd15), 1'b0, '0};
      directed[10] = '{1'b0, 5'd0,  frame_beat(11'h1F0, 4'd4),  1'b0, '0};
      directed[11] = '{1'b1, 5'd31, frame_beat(11'h7FF, 4'd8),  1'b0, '0};
      directed[12] = '{1'b1, 5'd1,  frame_beat(11'h7FF, 4'd0),  1'b0, '0};
      directed[13] = '{1'b0, 5'd0,  frame_beat(11'h123, 4'd9),  1'b0, '0};
      directed[14] = '{1'b0, 5'd0,  write_beat(4'd0, 11'h000, 11'h000, 4'd5, 1'b0), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd0, 1'b1}};
      directed[15] = '{1'b0, 5'd0,  frame_beat(11'h555, 4'd6),  1'b0, '0};
      directed[16] = '{1'b0, 5'd0,  frame_beat(11'h2AA, 4'd5),  1'b0, '0};
      directed[17] = '{1'b1, 5'd4,  frame_beat(11'h0F0, 4'd15), 1'b0, '0};
      directed[18] = '{1'b1, 5'd0,  frame_beat(11'h7FF, 4'd15), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_DONE, 4'd0, 1'b1}};
      directed[19] = '{1'b0, 5'd0,  write_beat(4'd15, 11'h000, 11'h000, 4'd0, 1'b0), 1'b1,
                       cmf_pkg::rsp_type'{cmf_pkg::KIND_ACK, 4'd15, 1'b1}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, light idling
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (directed[r]) begin
         if (directed[r].set_walk) begin
            settle();
            write_walk_len(directed[r].walk);
         end
         send_beat(directed[r].beat, directed[r].typed, directed[r].result);
         sender_gap();
      end

      // random part in phases, each with its own walk length and idling mix
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % PHASE_BEATS == 0) begin
            settle();
            case ($urandom_range(0, 9))
               0:       write_walk_len(5'd0);
               1:       write_walk_len(5'd31);
               2, 3:    write_walk_len(5'd16);
               4:       write_walk_len(5'd1);
               default: write_walk_len(5'($urandom_range(2, 15)));
            endcase
            case ($urandom_range(0, 2))
               0:       req_idle_pct = 0;
               1:       req_idle_pct = 20;
               default: req_idle_pct = 50;
            endcase
            case ($urandom_range(0, 2))
               0:       rsp_idle_pct = 0;
               1:       rsp_idle_pct = 20;
               default: rsp_idle_pct = 50;
            endcase
         end
         // closing stretch runs flat out
         if (i >= RANDOM_BEATS - QUIET_BEATS) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         raw  = {$urandom(), $urandom()};
         beat = cmf_pkg::req_type'(raw[$bits(cmf_pkg::req_type)-1:0]);
         n    = (walk_len > DEPTH) ? DEPTH : walk_len;

         if ($urandom_range(0, 99) < 30) begin
            beat.func = cmf_pkg::FUNC_WRITE;
            if (n > 0 && $urandom_range(0, 99) < 70)
               beat.entry_slot = 4'($urandom_range(0, n - 1));
            // mostly well-formed entries; the rest stay raw noise
            if ($urandom_range(0, 99) < 80) begin
               case ($urandom_range(0, 19))
                  0, 1, 2:    beat.entry_mask = 11'h000;
                  3, 4, 5, 6: beat.entry_mask = 11'h7FF;
                  default:    ;
               endcase
               beat.entry_ident = beat.entry_ident & beat.entry_mask;
               s = $urandom_range(0, 99);
               if (s < 40)      beat.entry_length = 4'd0;
               else if (s < 85) beat.entry_length = 4'($urandom_range(1, 8));
               else             beat.entry_length = 4'($urandom_range(9, 15));
               if ($urandom_range(0, 99) < 85) beat.entry_handled = 1'b1;
            end
         end else begin
            beat.func = cmf_pkg::FUNC_FRAME;
            // aim most frames at an active entry so matches and faults occur
            if (n > 0 && $urandom_range(0, 99) < 75) begin
               e = shadow_table[$urandom_range(0, n - 1)];
               beat.frame_id = (e.ident & e.mask) | (beat.frame_id & ~e.mask);
               if (e.length != 4'd0 && $urandom_range(0, 99) < 70)
                  beat.frame_length = e.length;
            end
         end

         send_beat(beat, 1'b0, '0);
         sender_gap();
      end

      // wind down
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d beats: %0d entry writes, %0d frames", n_writes + n_frames,
               n_writes, n_frames);
      $display("results seen: %0d matches, %0d length faults, %0d walks done, %0d acks",
               n_match, n_fault, n_done, n_ack);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/cmf_pkg.sv
rtl/cmf_table.sv
rtl/can_id_mask_filter_dispatch.sv
bench/tb_can_id_mask_filter_dispatch.sv
